### hw/rtl/lcd_segment_frame_sender_core_macros.svh
// ----------------------------------------------------------------------------
// lcd_segment_frame_sender_core_macros.svh
// Assertion macros for the LCD segment frame sender. Define ASSERT_OFF to
// compile the checks out.
// ----------------------------------------------------------------------------
`ifndef LCD_SEGMENT_FRAME_SENDER_CORE_MACROS_SVH
`define LCD_SEGMENT_FRAME_SENDER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define LSFS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define LSFS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LSFS_ASSERT(label, clk, rst, prop, msg)
`define LSFS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### hw/rtl/lsfs_pkg.sv
// ----------------------------------------------------------------------------
// lsfs_pkg
// Shared types and constants of the LCD segment frame sender.
// ----------------------------------------------------------------------------
package lsfs_pkg;

   localparam logic [63:0] READ_MASK      = 64'h00ff_0000_0000_000f;
   localparam logic [7:0]  CE_A           = 8'h01;
   localparam logic [7:0]  CE_B           = 8'h04;
   localparam logic [15:0] RELOAD_DEFAULT = 16'd25;

   // register index decoded from csr_paddr[2]
   localparam logic [0:0]  CSR_PRESCALE_RELOAD = 1'b0;

   typedef enum logic [2:0] {
      FUNC_WRITE  = 3'd0,
      FUNC_OR     = 3'd1,
      FUNC_CLEAR  = 3'd2,
      FUNC_READ   = 3'd3,
      FUNC_TICK   = 3'd4,
      FUNC_TXDONE = 3'd5
   } lsfs_func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FETCH
   } lsfs_state_type;

   typedef struct packed {
      logic accept;      // input word taken this cycle
      logic sweep;       // frame copy into the ring, one word a cycle
      logic fetch_push;  // ring read data is valid, push it as a result
   } lsfs_cmd_type;

   typedef struct packed {
      logic room;        // result queue can take one more word
      logic need_sweep;  // offered word is a tick that queues a frame
      logic need_fetch;  // offered word is a transmit done with data queued
      logic sweep_last;  // frame copy is on its last word
   } lsfs_status_type;

   typedef struct packed {
      logic        overflow;
      logic        blink_phase;
      logic [55:0] serial_payload;
      logic [7:0]  chip_enable;
      logic [63:0] read_data;
      logic        word_valid;
      logic        read_valid;
   } lsfs_rsp_type;

   // power-up content of one segment map word
   function automatic logic [63:0] seg_reset_word(input int unsigned idx);
      logic [63:0] w;
      w = '0;
      if (idx < 4) begin
         w[63:56] = (idx < 2) ? CE_A : CE_B;
         w[3:0]   = idx[0] ? 4'h1 : 4'h4;
      end
      return w;
   endfunction

endpackage

### hw/rtl/lsfs_ram.sv
// ----------------------------------------------------------------------------
// lsfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsfs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/lsfs_rsp_queue.sv
// ----------------------------------------------------------------------------
// lsfs_rsp_queue
// Two-word result queue: output register plus one skid entry.
// ----------------------------------------------------------------------------
module lsfs_rsp_queue
   import lsfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lsfs_rsp_type push_data,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output lsfs_rsp_type out_data
);

   logic [1:0]   count_ff, count_in;
   lsfs_rsp_type front_ff, front_in;
   lsfs_rsp_type spare_ff, spare_in;
   logic         pop;

   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff != 2'd2);
   assign out_data  = front_ff;

   always_comb begin
      count_in = count_ff;
      front_in = front_ff;
      spare_in = spare_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) front_in = push_data;
            else                  spare_in = push_data;
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            front_in = spare_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               front_in = push_data;
            end else begin
               front_in = spare_ff;
               spare_in = push_data;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 2'd0;
      else       count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      spare_ff <= spare_in;
   end

endmodule

### hw/rtl/lsfs_ctrl.sv
// ----------------------------------------------------------------------------
// lsfs_ctrl
// Sequencer: takes input words, runs frame copies and ring fetches.
// ----------------------------------------------------------------------------
module lsfs_ctrl
   import lsfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  lsfs_status_type status,
   output logic            req_tready,
   output lsfs_cmd_type    cmd
);

   lsfs_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.room) begin
               if (status.need_sweep)      state_in = ST_SWEEP;
               else if (status.need_fetch) state_in = ST_FETCH;
            end
         end
         ST_SWEEP: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_FETCH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = status.room;
            cmd.accept = req_tvalid && status.room;
         end
         ST_SWEEP: cmd.sweep      = 1'b1;
         ST_FETCH: cmd.fetch_push = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### hw/rtl/lsfs_datapath.sv
// ----------------------------------------------------------------------------
// lsfs_datapath
// Segment and blink maps, prescaler, blink counter, frame ring and results.
// ----------------------------------------------------------------------------
module lsfs_datapath
   import lsfs_pkg::*;
#(
   parameter int RING_FRAMES     = 5,
   parameter int WORDS_PER_FRAME = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  lsfs_cmd_type    cmd,
   output lsfs_status_type status,
   input  logic [2:0]      func,
   input  logic            target,
   input  logic [1:0]      word_index,
   input  logic [63:0]     seg_value,
   input  logic            full_read,
   input  logic [15:0]     prescale_reload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output lsfs_rsp_type    rsp_data
);

   localparam int HW    = $clog2(RING_FRAMES);
   localparam int PW    = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
   localparam int DEPTH = RING_FRAMES * WORDS_PER_FRAME;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [HW-1:0] HEAD_LAST = HW'(RING_FRAMES - 1);
   localparam logic [PW-1:0] PTR_LAST  = PW'(WORDS_PER_FRAME - 1);
   localparam logic [AW-1:0] WPF_A     = AW'(WORDS_PER_FRAME);

   logic [63:0]   seg_ff   [WORDS_PER_FRAME];
   logic [63:0]   seg_in   [WORDS_PER_FRAME];
   logic [63:0]   blink_ff [WORDS_PER_FRAME];
   logic [63:0]   blink_in [WORDS_PER_FRAME];
   logic [HW-1:0] head_ff, head_in;
   logic [HW-1:0] tail_ff, tail_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [15:0]   prescaler_ff, prescaler_in;
   logic [7:0]    counter_ff, counter_in;
   logic [PW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [AW-1:0] wr_base_ff, wr_base_in;
   logic          plain_ff, plain_in;

   lsfs_func_type fn;
   logic [2:0]    idx3;
   logic [PW-1:0] map_sel, map_addr;
   logic          in_map, map_wr;
   logic [63:0]   seg_word, blink_word, access_word, map_new, word0;
   logic [15:0]   pre_dec;
   logic          tick_zero, is_tick, is_txdone;
   logic [7:0]    counter_next;
   logic [HW-1:0] head_next, tail_next;
   logic          ring_full, ring_empty;
   logic          frame_queued;
   lsfs_rsp_type  acc_rsp, fetch_rsp, push_data;
   logic          acc_push, push, room;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [63:0]   ram_wdata, ram_rdata;
   logic          ram_re;

   // ---- decode ----
   assign fn        = lsfs_func_type'(func);
   assign is_tick   = (fn == FUNC_TICK);
   assign is_txdone = (fn == FUNC_TXDONE);
   assign idx3      = {1'b0, word_index};
   assign map_sel   = idx3[PW-1:0];
   assign in_map    = (int'(word_index) < WORDS_PER_FRAME);

   // one map read port: access index, or copy index during a frame copy
   assign map_addr    = cmd.sweep ? sweep_cnt_ff : map_sel;
   assign seg_word    = seg_ff[map_addr];
   assign blink_word  = blink_ff[map_addr];
   assign access_word = target ? blink_word : seg_word;

   assign pre_dec      = prescaler_ff - 16'd1;
   assign tick_zero    = (pre_dec == 16'd0);
   assign counter_next = counter_ff + 8'd1;

   assign head_next  = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next  = (tail_ff == HEAD_LAST) ? '0 : tail_ff + 1'b1;
   assign ring_full  = (head_next == tail_ff);
   assign ring_empty = (head_ff == tail_ff);

   assign status.need_sweep = is_tick && tick_zero && !ring_full;
   assign status.need_fetch = is_txdone && !ring_empty;
   assign status.sweep_last = (sweep_cnt_ff == PTR_LAST);
   assign status.room       = room;

   assign frame_queued = cmd.accept && status.need_sweep;

   // first word of a new frame, for the kick-start send
   assign word0 = counter_next[0] ? seg_ff[0] : (seg_ff[0] & blink_ff[0]);

   // ---- maps ----
   always_comb begin
      seg_in   = seg_ff;
      blink_in = blink_ff;
      map_wr   = cmd.accept && in_map && (fn inside {FUNC_WRITE, FUNC_OR, FUNC_CLEAR});
      case (fn)
         FUNC_WRITE: map_new = seg_value;
         FUNC_OR:    map_new = access_word | seg_value;
         FUNC_CLEAR: map_new = access_word & ~seg_value;
         default:    map_new = access_word;
      endcase
      if (map_wr) begin
         if (target) blink_in[map_sel] = map_new;
         else        seg_in[map_sel]   = map_new;
      end
   end

   // ---- prescaler, counter, ring pointers ----
   always_comb begin
      prescaler_in = prescaler_ff;
      counter_in   = counter_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ptr_in       = ptr_ff;
      sweep_cnt_in = cmd.sweep ? sweep_cnt_ff + 1'b1 : sweep_cnt_ff;
      wr_base_in   = wr_base_ff;
      plain_in     = plain_ff;
      if (cmd.accept && is_tick) begin
         prescaler_in = tick_zero ? prescale_reload : pre_dec;
         if (tick_zero) counter_in = counter_next;
      end
      if (frame_queued) begin
         head_in      = head_next;
         wr_base_in   = AW'(head_ff) * WPF_A;
         sweep_cnt_in = '0;
         plain_in     = counter_next[0];
         if (ring_empty) begin
            // kick-start sent word 0; a one-word frame is done at once
            if (PTR_LAST == '0) begin
               ptr_in  = '0;
               tail_in = tail_next;
            end else begin
               ptr_in = PW'(1);
            end
         end
      end
      if (cmd.accept && status.need_fetch) begin
         if (ptr_ff == PTR_LAST) begin
            ptr_in  = '0;
            tail_in = tail_next;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS_PER_FRAME; i++) begin
            seg_ff[i]   <= seg_reset_word(unsigned'(i));
            blink_ff[i] <= '0;
         end
         head_ff      <= '0;
         tail_ff      <= '0;
         ptr_ff       <= '0;
         prescaler_ff <= RELOAD_DEFAULT;
         counter_ff   <= '0;
         sweep_cnt_ff <= '0;
      end else begin
         seg_ff       <= seg_in;
         blink_ff     <= blink_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ptr_ff       <= ptr_in;
         prescaler_ff <= prescaler_in;
         counter_ff   <= counter_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_base_ff <= wr_base_in;
      plain_ff   <= plain_in;
   end

   // ---- frame ring ----
   assign ram_waddr = wr_base_ff + AW'(sweep_cnt_ff);
   assign ram_wdata = plain_ff ? seg_word : (seg_word & blink_word);
   assign ram_re    = cmd.accept && status.need_fetch;
   assign ram_raddr = AW'(tail_ff) * WPF_A + AW'(ptr_ff);

   lsfs_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (cmd.sweep),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---- results ----
   always_comb begin
      acc_rsp  = '0;
      acc_push = 1'b0;
      if (cmd.accept) begin
         case (fn)
            FUNC_READ: begin
               acc_push            = 1'b1;
               acc_rsp.read_valid  = 1'b1;
               acc_rsp.blink_phase = counter_ff[0];
               if (in_map) acc_rsp.read_data = full_read ? access_word
                                                         : (access_word & READ_MASK);
            end
            FUNC_TICK: begin
               if (tick_zero) begin
                  acc_push            = 1'b1;
                  acc_rsp.blink_phase = counter_next[0];
                  if (ring_full) begin
                     acc_rsp.overflow = 1'b1;
                  end else if (ring_empty) begin
                     acc_rsp.word_valid     = 1'b1;
                     acc_rsp.chip_enable    = word0[63:56];
                     acc_rsp.serial_payload = word0[55:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      fetch_rsp                = '0;
      fetch_rsp.word_valid     = 1'b1;
      fetch_rsp.chip_enable    = ram_rdata[63:56];
      fetch_rsp.serial_payload = ram_rdata[55:0];
      fetch_rsp.blink_phase    = counter_ff[0];
   end

   assign push      = acc_push || cmd.fetch_push;
   assign push_data = cmd.fetch_push ? fetch_rsp : acc_rsp;

   lsfs_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

### hw/rtl/lcd_segment_frame_sender_core.sv
// Reads, map writes and ticks are handled as they are accepted; a result is registered into the result queue.
// A tick that queues a frame keeps the input held while the frame is copied word by word into the ring RAM.
// A transmit done with data queued reads the ring RAM; the read is registered and the word is pushed from ST_FETCH.
// Throughput: one word per cycle for accesses while the result queue has room; results drain through a two-word queue.
// Reset (synchronous, high): maps to power-up content, pointers and counter to zero,
// prescaler and reload register to 25. The frame ring RAM is not cleared.
// ----------------------------------------------------------------------------
// lcd_segment_frame_sender_core
// Segment/blink map keeper with blink prescaler and five-frame LCD send ring.
// ----------------------------------------------------------------------------
`include "lcd_segment_frame_sender_core_macros.svh"

module lcd_segment_frame_sender_core
   import lsfs_pkg::*;
#(
   parameter int RING_FRAMES     = 5,
   parameter int WORDS_PER_FRAME = 4
) (
   input  logic         clock,
   input  logic         reset,
   // input stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // word_index[1:0], seg_value[65:2], full_read[66], pad
   input  logic [3:0]   req_tuser,   // func[2:0], target[3]
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // read_data[63:0], chip_enable[71:64],
                                     // serial_payload[127:72], blink_phase[128],
                                     // overflow[129], pad
   output logic [1:0]   rsp_tuser,   // read_valid[0], word_valid[1]
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   lsfs_cmd_type    cmd;
   lsfs_status_type status;
   lsfs_rsp_type    rsp;
   logic [15:0]     reload_ff, reload_in;
   logic            csr_wr, csr_hit;
   logic            fetch_go, sweep_go;

   // ---- configuration register ----
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2:2] == CSR_PRESCALE_RELOAD);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reload_in  = (csr_wr && csr_hit) ? csr_pwdata[15:0] : reload_ff;
   assign csr_prdata = csr_hit ? {16'b0, reload_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) reload_ff <= RELOAD_DEFAULT;
      else       reload_ff <= reload_in;
   end

   // ---- controller ----
   lsfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   // ---- datapath ----
   lsfs_datapath #(
      .RING_FRAMES     (RING_FRAMES),
      .WORDS_PER_FRAME (WORDS_PER_FRAME)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .func            (req_tuser[2:0]),
      .target          (req_tuser[3]),
      .word_index      (req_tdata[1:0]),
      .seg_value       (req_tdata[65:2]),
      .full_read       (req_tdata[66]),
      .prescale_reload (reload_ff),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_data        (rsp)
   );

   // ---- result packing ----
   assign rsp_tdata = {6'b0, rsp.overflow, rsp.blink_phase, rsp.serial_payload,
                       rsp.chip_enable, rsp.read_data};
   assign rsp_tuser = {rsp.word_valid, rsp.read_valid};

   // ---- checks ----
   assign fetch_go = cmd.accept && status.need_fetch;
   assign sweep_go = cmd.accept && status.need_sweep;

   // a ring fetch always lands in the result queue the next cycle
   `LSFS_ASSERT(a_fetch_push, clock, reset, fetch_go |=> cmd.fetch_push, "ring fetch not pushed")
   // a queued frame starts its copy and holds off the input
   `LSFS_ASSERT(a_sweep_start, clock, reset, sweep_go |=> cmd.sweep && !req_tready, "no frame copy")
   // never take a word without space for its result
   `LSFS_ASSERT_NEVER(a_ready_room, clock, reset, req_tready && !status.room, "ready, queue full")

endmodule
